>>> hdl/yolox_anchor_decode_filter_defines.svh
// assertion macros shared by the checker of the anchor decode filter
`ifndef YOLOX_ANCHOR_DECODE_FILTER_DEFINES_SVH
`define YOLOX_ANCHOR_DECODE_FILTER_DEFINES_SVH

// clocked assertion that is off while reset is held
`define YADF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also watches the reset cycles
`define YADF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/yadf_pkg.sv
// shared types, constants and helper functions of the anchor decode filter
package yadf_pkg;

  localparam int MAX_CLASSES  = 128;
  localparam int MAX_NET_SIDE = 1024;
  localparam int HEADER_LEN   = 5;
  localparam int LEVEL_COUNT  = 3;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_NET_WIDTH   = 3'd0,
    CFG_NET_HEIGHT  = 3'd1,
    CFG_CLASS_COUNT = 3'd2,
    CFG_SCORE_THR   = 3'd3,
    CFG_INV_SCALE_X = 3'd4,
    CFG_INV_SCALE_Y = 3'd5
  } cfg_idx_t;

  localparam logic signed [32:0] LOG2E_Q30 = 33'sd1549082005;
  localparam logic signed [31:0] MINUS_ONE = -32'sd65536;

  // one anchor row as handed from the front to the back
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] w;
    logic signed [31:0] h;
    logic signed [31:0] obj;
    logic signed [31:0] best;
    logic [6:0]         bidx;
    logic [6:0]         col;
    logic [6:0]         row;
    logic [1:0]         level;
    logic [14:0]        aid;
  } job_t;

  // horner coefficients of 2^f, applied from the inner term outward
  function automatic logic [17:0] horner_coef(input logic [2:0] k);
    logic [17:0] c;
    case (k)
      3'd0:    c = 18'd87;
      3'd1:    c = 18'd630;
      3'd2:    c = 18'd3638;
      3'd3:    c = 18'd15743;
      3'd4:    c = 18'd45426;
      default: c = 18'd65536;
    endcase
    return c;
  endfunction

  function automatic logic [10:0] side_eff(input logic [10:0] v);
    logic [10:0] s;
    s = v;
    if (s < 11'd32) s = 11'd32;
    if (s > 11'(MAX_NET_SIDE)) s = 11'(MAX_NET_SIDE);
    s = s & ~11'd31;
    return s;
  endfunction

  function automatic logic [7:0] classes_eff(input logic [7:0] v);
    logic [7:0] c;
    c = (v == 8'd0) ? 8'd1 : v;
    if (c > 8'(MAX_CLASSES)) c = 8'(MAX_CLASSES);
    return c;
  endfunction

  function automatic logic signed [31:0] sat_s40(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sh007FFFFFFF)
      r = 32'sh7FFFFFFF;
    else if (v < -40'sh0080000000)
      r = 32'sh80000000;
    else
      r = v[31:0];
    return r;
  endfunction

endpackage

>>> hdl/yadf_front.sv
// front: walks the row and anchor grid, tracks the best class, emits one job per row
module yadf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic signed [31:0]   in_raw_value,
  input  logic [10:0]          net_width,
  input  logic [10:0]          net_height,
  input  logic [7:0]           class_count,
  output logic                 push,
  output yadf_pkg::job_t       push_job
);
  import yadf_pkg::*;

  logic [7:0]         pos_r;
  logic [6:0]         col_r, row_r;
  logic [1:0]         lvl_r;
  logic [14:0]        aid_r;
  logic signed [31:0] x_r, y_r, w_r, h_r, obj_r, best_r;
  logic [6:0]         bidx_r;

  logic        acc, row_end, is_cls;
  logic [1:0]  lvl;
  logic [7:0]  nclass, cls_pos;
  logic [8:0]  pos_inc;
  logic [10:0] cols, rows;
  logic [7:0]  col_inc, row_inc;

  // classify the current element
  always_comb begin
    acc     = in_valid && !in_stall;
    lvl     = (lvl_r < 2'(LEVEL_COUNT)) ? lvl_r : 2'd0;
    nclass  = classes_eff(class_count);
    cls_pos = pos_r - 8'(HEADER_LEN);
    pos_inc = {1'b0, pos_r} + 9'd1;
    row_end = (pos_r >= 8'(HEADER_LEN)) && (pos_inc >= 9'(HEADER_LEN) + {1'b0, nclass});
    is_cls  = (pos_r >= 8'(HEADER_LEN)) && (cls_pos < nclass) && (in_raw_value > best_r);
    cols    = side_eff(net_width) >> (4'd3 + {2'b0, lvl});
    rows    = side_eff(net_height) >> (4'd3 + {2'b0, lvl});
    col_inc = {1'b0, col_r} + 8'd1;
    row_inc = {1'b0, row_r} + 8'd1;
  end

  // job for the back at the last element of a row
  always_comb begin
    push          = acc && row_end;
    push_job.x    = x_r;
    push_job.y    = y_r;
    push_job.w    = w_r;
    push_job.h    = h_r;
    push_job.obj  = obj_r;
    push_job.best = is_cls ? in_raw_value : best_r;
    push_job.bidx = is_cls ? cls_pos[6:0] : bidx_r;
    push_job.col  = col_r;
    push_job.row  = row_r;
    push_job.level = lvl;
    push_job.aid  = aid_r;
  end

  // row header capture
  always_ff @(posedge clk) begin
    if (acc) begin
      case (pos_r)
        8'd0: x_r <= in_raw_value;
        8'd1: y_r <= in_raw_value;
        8'd2: w_r <= in_raw_value;
        8'd3: h_r <= in_raw_value;
        default: ;
      endcase
    end
  end

  // row position, objectness, class scan and anchor grid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      col_r  <= '0;
      row_r  <= '0;
      lvl_r  <= '0;
      aid_r  <= '0;
      obj_r  <= '0;
      best_r <= MINUS_ONE;
      bidx_r <= '0;
    end else if (acc) begin
      if (pos_r == 8'd4) begin
        obj_r  <= in_raw_value;
        best_r <= MINUS_ONE;
        bidx_r <= '0;
      end else if (is_cls) begin
        best_r <= in_raw_value;
        bidx_r <= cls_pos[6:0];
      end
      if (row_end) begin
        pos_r <= '0;
        aid_r <= aid_r + 15'd1;
        col_r <= col_inc[6:0];
        lvl_r <= lvl;
        if ({3'b0, col_inc} >= cols) begin
          col_r <= '0;
          row_r <= row_inc[6:0];
          if ({3'b0, row_inc} >= rows) begin
            row_r <= '0;
            if (lvl == 2'(LEVEL_COUNT - 1)) begin
              lvl_r <= '0;
              aid_r <= '0;
            end else begin
              lvl_r <= lvl + 2'd1;
            end
          end
        end
      end else begin
        pos_r <= pos_inc[7:0];
      end
    end
  end

endmodule

>>> hdl/yadf_queue.sv
// short job queue between front and back
module yadf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  yadf_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output yadf_pkg::job_t head_job
);
  import yadf_pkg::*;

  job_t       slot_r [4];
  logic [1:0] wr_r, rd_r;
  logic [2:0] cnt_r;

  assign full       = (cnt_r == 3'd4);
  assign head_valid = (cnt_r != 3'd0);
  assign head_job   = slot_r[rd_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 2'd1;
      if (pop)  rd_r <= rd_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, push} - {2'b0, pop};
    end
  end

endmodule

>>> hdl/yadf_back.sv
// back: score filter, box decode with exp, corner scaling and result register
module yadf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  yadf_pkg::job_t      job,
  output logic                pop,
  input  logic [16:0]         score_threshold,
  input  logic [31:0]         inverse_scale_x,
  input  logic [31:0]         inverse_scale_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_box_left,
  output logic signed [31:0]  out_box_top,
  output logic signed [31:0]  out_box_right,
  output logic signed [31:0]  out_box_bottom,
  output logic [16:0]         out_final_score,
  output logic [6:0]          out_class_id,
  output logic [14:0]         out_anchor_id
);
  import yadf_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_SCORE, ST_LOG, ST_HORN, ST_EDGE, ST_OUT} state_t;

  state_t             state_r;
  logic signed [66:0] prod_r;
  logic [2:0]         k_r, ecnt_r;
  logic               side_r, neg_r, out_valid_r;
  logic [15:0]        f_r;
  logic signed [20:0] n_r;
  logic signed [31:0] cx_r, cy_r, bw_r, bh_r;
  logic signed [31:0] edge_r [4];
  logic [16:0]        score_r;

  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] score_w;
  logic signed [50:0] thr_s;
  logic               keep;
  logic [4:0]         shamt;
  logic signed [39:0] cx_w, cy_w;
  logic signed [36:0] y_w;
  logic [17:0]        p_w;
  logic [31:0]        exp_w;
  logic [38:0]        up_w;
  logic [20:0]        nneg;
  logic signed [31:0] size_w;
  logic signed [33:0] cx2, cy2, a2;
  logic [33:0]        mag;
  logic               neg_w;
  logic [31:0]        scl;
  logic [49:0]        q_w;
  logic signed [31:0] edge_w;

  // filter, centre and exp datapath
  always_comb begin
    score_w = prod_r[66:16];
    thr_s   = {34'b0, score_threshold};
    keep    = (signed'({{19{job.obj[31]}}, job.obj}) >= thr_s) && (score_w >= thr_s);
    shamt   = 5'd3 + {3'b0, job.level};
    cx_w    = ({{8{job.x[31]}}, job.x} + {17'b0, job.col, 16'b0}) <<< shamt;
    cy_w    = ({{8{job.y[31]}}, job.y} + {17'b0, job.row, 16'b0}) <<< shamt;
    y_w     = prod_r[66:30];
    p_w     = horner_coef(k_r) + prod_r[33:16];
    up_w    = {21'b0, p_w} << n_r[4:0];
    nneg    = -n_r;
    if (!n_r[20]) begin
      if (n_r > 21'sd20 || up_w > 39'h007FFFFFFF) exp_w = 32'h7FFFFFFF;
      else exp_w = up_w[31:0];
    end else begin
      if (nneg >= 21'd32) exp_w = '0;
      else exp_w = {14'b0, p_w} >> nneg[4:0];
    end
    size_w = sat_s40(signed'({8'b0, exp_w} << shamt));
  end

  // corner operand and result for one edge
  always_comb begin
    cx2 = {{1{cx_r[31]}}, cx_r, 1'b0};
    cy2 = {{1{cy_r[31]}}, cy_r, 1'b0};
    case (ecnt_r[1:0])
      2'd0:    a2 = cx2 - {{2{1'b0}}, bw_r};
      2'd1:    a2 = cy2 - {{2{1'b0}}, bh_r};
      2'd2:    a2 = cx2 + {{2{1'b0}}, bw_r};
      default: a2 = cy2 + {{2{1'b0}}, bh_r};
    endcase
    neg_w = a2[33];
    mag   = neg_w ? 34'(-a2) : 34'(a2);
    scl   = ecnt_r[0] ? inverse_scale_y : inverse_scale_x;
    q_w   = prod_r[66:17] + {49'b0, (neg_r && (prod_r[16:0] != 17'd0))};
    if (prod_r[64]) begin
      edge_w = neg_r ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else if (!neg_r) begin
      edge_w = (q_w > 50'h7FFFFFFF) ? 32'sh7FFFFFFF : signed'(q_w[31:0]);
    end else begin
      edge_w = (q_w > 50'h80000000) ? 32'sh80000000 : signed'(32'(-q_w[31:0]));
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = {{2{job.obj[31]}}, job.obj};
    mul_b = {job.best[31], job.best};
    case (state_r)
      ST_SCORE: begin
        mul_a = {{2{job.w[31]}}, job.w};
        mul_b = LOG2E_Q30;
      end
      ST_LOG: begin
        mul_a = 34'sd10;
        mul_b = {17'b0, y_w[15:0]};
      end
      ST_HORN: begin
        mul_a = (k_r == 3'd5) ? {{2{job.h[31]}}, job.h} : {16'b0, p_w};
        mul_b = (k_r == 3'd5) ? LOG2E_Q30 : {17'b0, f_r};
      end
      ST_EDGE: begin
        mul_a = mag;
        mul_b = {1'b0, scl};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign pop = (state_r == ST_SCORE && !keep) ||
               (state_r == ST_OUT && (!out_valid_r || !out_stall));

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      ecnt_r      <= '0;
      side_r      <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_OUT) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (job_valid) state_r <= ST_SCORE;
        end
        ST_SCORE: begin
          if (!keep) begin
            state_r <= ST_IDLE;
          end else begin
            score_r <= (score_w > 51'sd65536) ? 17'd65536 : score_w[16:0];
            cx_r    <= sat_s40(cx_w);
            cy_r    <= sat_s40(cy_w);
            side_r  <= 1'b0;
            state_r <= ST_LOG;
          end
        end
        ST_LOG: begin
          f_r     <= y_w[15:0];
          n_r     <= y_w[36:16];
          k_r     <= '0;
          state_r <= ST_HORN;
        end
        ST_HORN: begin
          if (k_r == 3'd5) begin
            if (!side_r) begin
              bw_r    <= size_w;
              side_r  <= 1'b1;
              state_r <= ST_LOG;
            end else begin
              bh_r    <= size_w;
              ecnt_r  <= '0;
              state_r <= ST_EDGE;
            end
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        ST_EDGE: begin
          if (ecnt_r != 3'd0) edge_r[ecnt_r[1:0] - 2'd1] <= edge_w;
          neg_r  <= neg_w;
          ecnt_r <= ecnt_r + 3'd1;
          if (ecnt_r == 3'd4) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r     <= 1'b1;
            out_box_left    <= edge_r[0];
            out_box_top     <= edge_r[1];
            out_box_right   <= edge_r[2];
            out_box_bottom  <= edge_r[3];
            out_final_score <= score_r;
            out_class_id    <= job.bidx;
            out_anchor_id   <= job.aid;
            state_r         <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hdl/yolox_anchor_decode_filter.sv
// top level of the anchor decode filter: config registers, front, queue and back
//
// Usage: the detector tensor streams in on in_raw_value, one signed Q16.16
// element per accepted item (in_valid high, in_stall low), rows of
// x, y, w, h, objectness and class_count scores in anchor order.
// The front takes one element per cycle while in_stall is low and hands
// each finished row to a four-deep job queue. The back drops a row after
// fetch and score check; a kept row holds it (one shared multiplier: fetch,
// score check, two log2 steps, twelve Horner steps, five corner steps,
// output load) and then sits in the output register until out_stall is low.
// Throughput: one element per cycle while rows are long enough to cover the
// back's time per row; in_stall rises only while the job queue is full.
// A kept row that finds the back free passes the queue and all back steps
// before its result shows; a busy back adds the time it still needs.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Reset (rst_n low, synchronous) restores register defaults, restarts the
// grid at the first anchor of stride 8 and empties queue and output.
// A stalled result holds its fields until taken; the queue then fills and
// the input side stalls.
module yolox_anchor_decode_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_raw_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_box_left,
  output logic signed [31:0] out_box_top,
  output logic signed [31:0] out_box_right,
  output logic signed [31:0] out_box_bottom,
  output logic [16:0]        out_final_score,
  output logic [6:0]         out_class_id,
  output logic [14:0]        out_anchor_id
);
  import yadf_pkg::*;

  logic [10:0] net_width_r, net_height_r;
  logic [7:0]  class_count_r;
  logic [16:0] score_thr_r;
  logic [31:0] inv_sx_r, inv_sy_r;

  logic q_full, q_valid, push, pop;
  job_t push_job, head_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_width_r   <= 11'd640;
      net_height_r  <= 11'd640;
      class_count_r <= 8'd80;
      score_thr_r   <= 17'd32768;
      inv_sx_r      <= 32'd65536;
      inv_sy_r      <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NET_WIDTH:   net_width_r   <= cfg_data[10:0];
        CFG_NET_HEIGHT:  net_height_r  <= cfg_data[10:0];
        CFG_CLASS_COUNT: class_count_r <= cfg_data[7:0];
        CFG_SCORE_THR:   score_thr_r   <= cfg_data[16:0];
        CFG_INV_SCALE_X: inv_sx_r      <= cfg_data;
        CFG_INV_SCALE_Y: inv_sy_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;

  yadf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_raw_value(in_raw_value),
    .net_width   (net_width_r),
    .net_height  (net_height_r),
    .class_count (class_count_r),
    .push        (push),
    .push_job    (push_job)
  );

  yadf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .head_valid(q_valid),
    .head_job  (head_job)
  );

  yadf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (q_valid),
    .job            (head_job),
    .pop            (pop),
    .score_threshold(score_thr_r),
    .inverse_scale_x(inv_sx_r),
    .inverse_scale_y(inv_sy_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_box_left   (out_box_left),
    .out_box_top    (out_box_top),
    .out_box_right  (out_box_right),
    .out_box_bottom (out_box_bottom),
    .out_final_score(out_final_score),
    .out_class_id   (out_class_id),
    .out_anchor_id  (out_anchor_id)
  );

endmodule

>>> hdl/yadf_checker.sv
// port-level checker of the anchor decode filter and its bind
`include "yolox_anchor_decode_filter_defines.svh"

module yadf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_box_left,
  input logic signed [31:0] out_box_right,
  input logic signed [31:0] out_box_top,
  input logic signed [31:0] out_box_bottom,
  input logic [16:0]        out_final_score
);

  // no result survives reset
  `YADF_ASSERT_RST(a_rst_clear, !rst_n |=> !out_valid, "result valid after reset")

  // a stalled result holds
  `YADF_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_box_left), "stalled result changed")

  // score saturates at one
  `YADF_ASSERT(a_score_max, out_valid |-> out_final_score <= 17'd65536, "final score above one")

  // corners are ordered since sizes and scales are never negative
  `YADF_ASSERT(a_order, out_valid |-> out_box_left <= out_box_right && out_box_top <= out_box_bottom, "box corners out of order")

endmodule

bind yolox_anchor_decode_filter yadf_checker u_yadf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_box_left   (out_box_left),
  .out_box_right  (out_box_right),
  .out_box_top    (out_box_top),
  .out_box_bottom (out_box_bottom),
  .out_final_score(out_final_score)
);

>>> verif/testbench.sv
// self-checking testbench of the anchor decode filter: directed rows, then random frames
module testbench;
  import yadf_pkg::*;

  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] top;
    logic signed [31:0] right;
    logic signed [31:0] bottom;
    logic [16:0]        score;
    logic [6:0]         cls;
    logic [14:0]        aid;
  } box_t;

  typedef struct packed {
    logic signed [31:0] raw;
    bit                 typed;
    box_t               want;
  } stim_t;

  localparam longint INT_MAX = 64'sd2147483647;
  localparam longint INT_MIN = -64'sd2147483648;
  localparam int DRAIN_CYCLES = 40;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_raw_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_box_left, out_box_top, out_box_right, out_box_bottom;
  logic [16:0]        out_final_score;
  logic [6:0]         out_class_id;
  logic [14:0]        out_anchor_id;

  yolox_anchor_decode_filter uut (.*);

  // shadow registers and grid state of the decoder
  logic [10:0] sh_width, sh_height;
  logic [7:0]  sh_classes;
  logic [16:0] sh_thr;
  logic [31:0] sh_scale_x, sh_scale_y;
  int          row_pos, level, col, row, anchor_idx, best_idx;
  longint      box_reg [4];
  longint      obj_held, best_score;
  bit          alive;

  box_t        pending_boxes [$];
  int          mismatch_count = 0;
  int          boxes_taken = 0;
  bit          quiet = 1'b0;

  // directed rows for class count 1: a plain box, extremes, two drops
  stim_t dir_tab [24] = '{
    '{32'sd0, 1'b0, '0}, '{32'sd0, 1'b0, '0}, '{32'sd0, 1'b0, '0},
    '{32'sd0, 1'b0, '0}, '{32'sd65536, 1'b0, '0},
    '{32'sd65536, 1'b1, '{-32'sd262144, -32'sd262144, 32'sd262144, 32'sd262144,
                          17'd65536, 7'd0, 15'd0}},
    '{32'sh7FFFFFFF, 1'b0, '0}, '{32'sh80000000, 1'b0, '0},
    '{32'sh7FFFFFFF, 1'b0, '0}, '{32'sh80000000, 1'b0, '0},
    '{32'sh7FFFFFFF, 1'b0, '0}, '{32'sh7FFFFFFF, 1'b0, '0},
    '{32'sd0, 1'b0, '0}, '{32'sd0, 1'b0, '0}, '{32'sd0, 1'b0, '0},
    '{32'sd0, 1'b0, '0}, '{32'sd32767, 1'b0, '0}, '{32'sd65536, 1'b0, '0},
    '{32'sd0, 1'b0, '0}, '{32'sd0, 1'b0, '0}, '{32'sd0, 1'b0, '0},
    '{32'sd0, 1'b0, '0}, '{32'sd65536, 1'b0, '0}, '{32'sd32767, 1'b0, '0}
  };

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #40000000;
    $display("yolox_anchor_decode_filter regression: fail");
    $finish;
  end

  function automatic longint sat32(longint v);
    if (v > INT_MAX) return INT_MAX;
    if (v < INT_MIN) return INT_MIN;
    return v;
  endfunction

  // e^t in q16.16 through 2^(t*log2 e)
  function automatic longint exp_fix(longint t);
    longint y, n;
    longint unsigned f, p, v;
    longint unsigned coef [6] = '{87, 630, 3638, 15743, 45426, 65536};
    y = (t * longint'(LOG2E_Q30)) >>> 30;
    n = y >>> 16;
    f = longint'(y - n * 65536);
    p = 10;
    for (int k = 0; k < 6; k++) p = coef[k] + ((p * f) >> 16);
    if (n >= 0) begin
      if (n > 20) return INT_MAX;
      v = p << n;
      return (v > 64'h7FFFFFFF) ? INT_MAX : longint'(v);
    end
    if (-n >= 32) return 0;
    return longint'(p >> (-n));
  endfunction

  // corner in q16.17 times inverse scale, floored back to q16.16
  function automatic longint scale_corner(longint a2, logic [31:0] s);
    bit neg;
    logic [127:0] m, p, q;
    neg = a2 < 0;
    m = neg ? 128'(-a2) : 128'(a2);
    p = m * 128'(s);
    q = p >> 17;
    if (!neg) return (q > 128'h7FFFFFFF) ? INT_MAX : longint'(q);
    if (p[16:0] != 0) q = q + 1;
    if (q > 128'h80000000) return INT_MIN;
    return -longint'(q);
  endfunction

  function automatic int side_cells(logic [10:0] v, int lvl);
    int s;
    s = int'(v);
    if (s < 32) s = 32;
    if (s > MAX_NET_SIDE) s = MAX_NET_SIDE;
    s = s & ~31;
    return s >> (3 + lvl);
  endfunction

  function automatic int class_total();
    int c;
    c = (sh_classes == 0) ? 1 : int'(sh_classes);
    if (c > MAX_CLASSES) c = MAX_CLASSES;
    if (c > 128) c = 128;
    return c;
  endfunction

  // advance the decoder by one element, returns 1 when a box is due
  function automatic bit decode_element(logic signed [31:0] raw, output box_t res);
    longint t, stride, thr, sc, cx2, cy2;
    int nc, lvl;
    bit hit;
    t = longint'(raw);
    lvl = (level < LEVEL_COUNT) ? level : 0;
    stride = 64'sd8 << lvl;
    nc = class_total();
    thr = longint'(sh_thr);
    hit = 1'b0;
    res = '0;
    case (row_pos)
      0: box_reg[0] = sat32((t + (longint'(col) << 16)) * stride);
      1: box_reg[1] = sat32((t + (longint'(row) << 16)) * stride);
      2, 3: box_reg[row_pos] = sat32(exp_fix(t) * stride);
      4: begin
        obj_held = t;
        alive = t >= thr;
        best_score = -65536;
        best_idx = 0;
      end
      default: begin
        if (row_pos - HEADER_LEN < nc && t > best_score) begin
          best_score = t;
          best_idx = row_pos - HEADER_LEN;
        end
      end
    endcase
    if (row_pos + 1 >= HEADER_LEN + nc && row_pos >= HEADER_LEN) begin
      if (alive) begin
        sc = (obj_held * best_score) >>> 16;
        if (sc >= thr) begin
          cx2 = box_reg[0] * 2;
          cy2 = box_reg[1] * 2;
          res.left = 32'(scale_corner(cx2 - box_reg[2], sh_scale_x));
          res.top = 32'(scale_corner(cy2 - box_reg[3], sh_scale_y));
          res.right = 32'(scale_corner(cx2 + box_reg[2], sh_scale_x));
          res.bottom = 32'(scale_corner(cy2 + box_reg[3], sh_scale_y));
          res.score = (sc > 65536) ? 17'd65536 : 17'(sc);
          res.cls = 7'(best_idx);
          res.aid = 15'(anchor_idx);
          hit = 1'b1;
        end
      end
      row_pos = 0;
      alive = 1'b0;
      anchor_idx = (anchor_idx + 1) & 32'h7FFF;
      col++;
      if (col >= side_cells(sh_width, lvl)) begin
        col = 0;
        row++;
        if (row >= side_cells(sh_height, lvl)) begin
          row = 0;
          lvl++;
          if (lvl >= LEVEL_COUNT) begin
            lvl = 0;
            anchor_idx = 0;
          end
        end
      end
      level = lvl;
    end else begin
      row_pos++;
    end
    return hit;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_NET_WIDTH:   sh_width = val[10:0];
      CFG_NET_HEIGHT:  sh_height = val[10:0];
      CFG_CLASS_COUNT: sh_classes = val[7:0];
      CFG_SCORE_THR:   sh_thr = val[16:0];
      CFG_INV_SCALE_X: sh_scale_x = val;
      CFG_INV_SCALE_Y: sh_scale_y = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(logic [31:0] w, logic [31:0] h, logic [31:0] c,
                            logic [31:0] thr, logic [31:0] sx, logic [31:0] sy);
    write_reg(CFG_NET_WIDTH, w);
    write_reg(CFG_NET_HEIGHT, h);
    write_reg(CFG_CLASS_COUNT, c);
    write_reg(CFG_SCORE_THR, thr);
    write_reg(CFG_INV_SCALE_X, sx);
    write_reg(CFG_INV_SCALE_Y, sy);
    cfg_we <= 1'b0;
  endtask

  // offer one element, predict once it is taken
  task automatic send_element(logic signed [31:0] raw, bit typed, box_t want);
    int gap;
    box_t res;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_raw_value <= raw;
    do @(posedge clk); while (in_stall);
    if (decode_element(raw, res)) pending_boxes = {pending_boxes, (typed ? want : res)};
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [31:0] any_value();
    return $urandom;
  endfunction

  // one anchor row with mostly plausible content
  task automatic send_row();
    int len;
    logic signed [31:0] v;
    len = HEADER_LEN + class_total();
    for (int p = 0; p < len; p++) begin
      if ($urandom_range(0, 7) == 0) v = any_value();
      else if (p < 2) v = $signed($urandom_range(0, 131072)) - 32'sd65536;
      else if (p < 4) v = $signed($urandom_range(0, 655360)) - 32'sd327680;
      else v = $urandom_range(0, 131072);
      send_element(v, 1'b0, '0);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    box_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_box_left, out_box_top, out_box_right, out_box_bottom,
              out_final_score, out_class_id, out_anchor_id};
      boxes_taken++;
      if (pending_boxes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected box: anchor %0d class %0d", got.aid, got.cls);
      end else begin
        want = pending_boxes.pop_front();
        if (got.left !== want.left || got.top !== want.top ||
            got.right !== want.right || got.bottom !== want.bottom ||
            got.score !== want.score || got.cls !== want.cls || got.aid !== want.aid) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("box mismatch: expected %0d %0d %0d %0d s%0d c%0d a%0d, got %0d %0d %0d %0d s%0d c%0d a%0d",
                     want.left, want.top, want.right, want.bottom, want.score, want.cls,
                     want.aid, got.left, got.top, got.right, got.bottom, got.score,
                     got.cls, got.aid);
        end
      end
    end
  end

  // result side stalls, with one long hold-off to back the block up
  initial begin
    int n;
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      n = quiet ? 0 : $urandom_range(0, 3);
      if (!held && boxes_taken >= 30) begin
        n = 400;
        held = 1'b1;
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // stimulus
  initial begin
    int sent;
    int budget;
    sh_width = 640; sh_height = 640; sh_classes = 80; sh_thr = 32768;
    sh_scale_x = 65536; sh_scale_y = 65536;
    row_pos = 0; level = 0; col = 0; row = 0; anchor_idx = 0;
    obj_held = 0; best_score = -65536; best_idx = 0; alive = 1'b0;
    foreach (box_reg[k]) box_reg[k] = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows
    set_config(32, 32, 1, 32768, 65536, 65536);
    foreach (dir_tab[k]) send_element(dir_tab[k].raw, dir_tab[k].typed, dir_tab[k].want);
    wait_idle();

    // random phases, the first three at register extremes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(0, 32, 0, 0, 0, 32'hFFFFFFFF);
        1: set_config(64, 2047, 200, 65536, 1, 65536);
        2: set_config(1024, 32, 255, $urandom_range(0, 40000), 65536, 32'hFFFFFFFF);
        default: set_config(32 * $urandom_range(1, 3), 32 * $urandom_range(1, 2),
                            $urandom_range(1, 6), $urandom_range(0, 65536),
                            $urandom_range(0, 1) ? 32'd65536 : $urandom,
                            $urandom_range(0, 1) ? $urandom_range(1, 200000) : $urandom);
      endcase
      quiet = (ph == 5);
      budget = (ph == 2) ? 260 : 190;
      sent = 0;
      while (sent < budget) begin
        if (ph == 4 && sent >= 50 && sent < 60) begin
          wait_idle();
          sent = 60;
        end
        if ($urandom_range(0, 11) == 0) begin
          send_element(any_value(), 1'b0, '0);
          sent++;
        end else begin
          send_row();
          sent += HEADER_LEN + class_total();
        end
      end
      wait_idle();
      quiet = 1'b0;
    end

    if (mismatch_count == 0 && pending_boxes.size() == 0)
      $display("yolox_anchor_decode_filter regression: pass");
    else
      $display("yolox_anchor_decode_filter regression: fail");
    $finish;
  end

endmodule
